// File: hdl/hpf_srtn_process_scheduler_defines.svh
// ---------------------------------------------------------------------------
// Scheduler assertion macros
// Shared concurrent assertion forms used by the scheduler checker.
// ---------------------------------------------------------------------------
`ifndef HPF_SRTN_PROCESS_SCHEDULER_DEFINES_SVH
`define HPF_SRTN_PROCESS_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define HSS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hss: same-cycle implication violated");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define HSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hss: next-cycle implication violated");

`endif

// File: hdl/hss_pkg.sv
// ---------------------------------------------------------------------------
// Scheduler package
// Sizes, codes, heap entry type and helper functions of the task scheduler.
// ---------------------------------------------------------------------------
package hss_pkg;

  localparam int unsigned MAX_TASKS = 64;
  localparam int unsigned KEY_BITS  = 16;
  localparam int unsigned IDX_W     = $clog2(MAX_TASKS);
  localparam int unsigned CNT_W     = $clog2(MAX_TASKS + 1);

  localparam logic [KEY_BITS-1:0] KEY_MAX   = '1;
  localparam logic [47:0]         KEY_MAX_W = (48'd1 << KEY_BITS) - 48'd1;

  localparam logic [1:0] REG_SCHED_MODE = 2'd0;

  typedef enum logic [1:0] {
    KIND_ARRIVAL,
    KIND_REPORT,
    KIND_DISPATCH,
    KIND_NOP
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_POP,
    S_PUSH,
    S_PLACE,
    S_START,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [IDX_W-1:0]    tid;
  } heap_ent_t;

  typedef logic [IDX_W-1:0] id_map_t [64];

  function automatic id_map_t build_id_map();
    id_map_t m;
    for (int i = 0; i < 64; i++) begin
      m[i] = IDX_W'(i % MAX_TASKS);
    end
    return m;
  endfunction

  localparam id_map_t ID_MAP = build_id_map();

  function automatic logic [KEY_BITS-1:0] sat_key(input logic [15:0] v);
    logic [47:0] wide;
    wide = {32'd0, v};
    if (wide > KEY_MAX_W) begin
      return KEY_MAX;
    end
    return wide[KEY_BITS-1:0];
  endfunction

  function automatic logic ent_less(input heap_ent_t a, input heap_ent_t b);
    return (a.key < b.key) || ((a.key == b.key) && (a.tid < b.tid));
  endfunction

  function automatic logic [5:0] to_id6(input logic [IDX_W-1:0] idx);
    logic [IDX_W+5:0] w;
    w = {6'd0, idx};
    return w[5:0];
  endfunction

endpackage

// File: hdl/hss_if.sv
// ---------------------------------------------------------------------------
// Scheduler channel interfaces
// Valid/ready channels for scheduling events in and status words out.
// ---------------------------------------------------------------------------
interface hss_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [5:0]  proc_id;
  logic [15:0] priority_req;
  logic [15:0] run_time;
  logic [15:0] reported_remaining;
  logic [15:0] now;

  modport source (output valid, kind, proc_id, priority_req, run_time,
                  reported_remaining, now, input ready);
  modport sink (input valid, kind, proc_id, priority_req, run_time,
                reported_remaining, now, output ready);
endinterface

interface hss_out_if;
  logic        valid;
  logic        ready;
  logic        run_valid;
  logic [5:0]  run_id;
  logic [15:0] send_remaining;
  logic        msg_valid;
  logic [15:0] start_time;
  logic        finished;
  logic [15:0] finish_time;
  logic        overflow;

  modport source (output valid, run_valid, run_id, send_remaining, msg_valid,
                  start_time, finished, finish_time, overflow, input ready);
  modport sink (input valid, run_valid, run_id, send_remaining, msg_valid,
                start_time, finished, finish_time, overflow, output ready);
endinterface

// File: hdl/hpf_srtn_process_scheduler.sv
// ---------------------------------------------------------------------------
// HPF / SRTN process scheduler
// Min-heap ready queue and task table held in RAM, walked by a sequencer.
// ---------------------------------------------------------------------------
// Events enter on in_i: arrival, remaining-time report, dispatch or no-op.
// Every accepted word yields exactly one status word on out_o.
// sched_mode is written through the APB port; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// A report, a no-op or a full-heap arrival goes straight to its status word.
// An arrival climbs the heap from its new leaf; a dispatch reads the root,
// and one that pops sifts the last entry down the heap, re-queues a task
// preempted in SRTN mode by the same climb, and then starts the popped task.
// The single write port of the heap RAM sets a pace of one level per cycle.
// One event is in progress at a time; in_i.ready is high only when idle,
// so the next word is taken only after the status word is loaded.
// A finished status word waits in the output register, and the next event
// is taken meanwhile; it stalls only before its own result if out_o is busy.
// Reset empties the heap, clears the running task and selects HPF mode;
// the RAM contents are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
module hpf_srtn_process_scheduler import hss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  hss_in_if.sink      in_i,
  hss_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  function automatic logic [IDX_W-1:0] parent_of(input logic [IDX_W-1:0] x);
    logic [IDX_W-1:0] y;
    y = x - IDX_W'(1);
    return y >> 1;
  endfunction

  function automatic logic [IDX_W+1:0] child_l(input logic [IDX_W-1:0] x);
    return {1'b0, x, 1'b1};
  endfunction

  state_e              state_q, state_d;
  logic                mode_q, mode_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                run_valid_q, run_valid_d;
  logic [IDX_W-1:0]    run_task_q, run_task_d;
  logic [15:0]         run_rem_q, run_rem_d;
  logic [15:0]         run_start_q, run_start_d;
  logic                preempt_q, preempt_d;
  logic                out_valid_q, out_valid_d;
  kind_e               kind_q, kind_d;
  logic [15:0]         now_q, now_d;
  logic                fin_q, fin_d;
  logic                ovf_q, ovf_d;
  logic [IDX_W-1:0]    hole_q, hole_d;
  heap_ent_t           ent_q, ent_d;
  logic [IDX_W-1:0]    t_q, t_d;
  logic                o_run_valid_q, o_run_valid_d;
  logic [5:0]          o_run_id_q, o_run_id_d;
  logic [15:0]         o_send_q, o_send_d;
  logic                o_msg_q, o_msg_d;
  logic [15:0]         o_start_q, o_start_d;
  logic                o_fin_q, o_fin_d;
  logic [15:0]         o_fin_time_q, o_fin_time_d;
  logic                o_ovf_q, o_ovf_d;

  logic                h_we;
  logic [IDX_W-1:0]    h_waddr;
  heap_ent_t           h_wdata;
  logic [IDX_W-1:0]    h_raddr_a, h_raddr_b;
  heap_ent_t           h_rdata_a, h_rdata_b;

  logic                rt_we, rem_we, st_we;
  logic [IDX_W-1:0]    rt_waddr, rem_waddr, st_waddr;
  logic [15:0]         rt_wdata, rem_wdata, st_wdata;
  logic                tab_re;
  logic [IDX_W-1:0]    tab_raddr;
  logic [15:0]         rt_rd, rem_rd, st_rd;

  logic                acc;
  logic                out_free;
  logic                heap_full;
  logic [IDX_W-1:0]    acc_id;
  logic [CNT_W-1:0]    cnt_m1;
  logic [IDX_W-1:0]    hole_par;
  logic [IDX_W+1:0]    cl_idx, cr_idx;
  logic                l_ok, r_ok;
  heap_ent_t           best;
  logic [IDX_W-1:0]    best_idx;
  logic                moved;
  logic                push_up;
  logic                do_pop;
  logic                start_stamp;
  state_e              push_exit;

  hss_ram #(.WIDTH($bits(heap_ent_t)), .DEPTH(MAX_TASKS)) u_heap_a (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .re_i(1'b1), .raddr_i(h_raddr_a), .rdata_o(h_rdata_a)
  );

  hss_ram #(.WIDTH($bits(heap_ent_t)), .DEPTH(MAX_TASKS)) u_heap_b (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .re_i(1'b1), .raddr_i(h_raddr_b), .rdata_o(h_rdata_b)
  );

  hss_ram #(.WIDTH(16), .DEPTH(MAX_TASKS)) u_run_time (
    .clk_i, .we_i(rt_we), .waddr_i(rt_waddr), .wdata_i(rt_wdata),
    .re_i(tab_re), .raddr_i(tab_raddr), .rdata_o(rt_rd)
  );

  hss_ram #(.WIDTH(16), .DEPTH(MAX_TASKS)) u_remaining (
    .clk_i, .we_i(rem_we), .waddr_i(rem_waddr), .wdata_i(rem_wdata),
    .re_i(tab_re), .raddr_i(tab_raddr), .rdata_o(rem_rd)
  );

  hss_ram #(.WIDTH(16), .DEPTH(MAX_TASKS)) u_start (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .re_i(tab_re), .raddr_i(tab_raddr), .rdata_o(st_rd)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign acc        = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign heap_full  = (cnt_q == CNT_W'(MAX_TASKS));
  assign acc_id     = ID_MAP[in_i.proc_id];
  assign cnt_m1     = cnt_q - CNT_W'(1);
  assign hole_par   = parent_of(hole_q);
  assign cl_idx     = child_l(hole_q);
  assign cr_idx     = cl_idx + (IDX_W + 2)'(1);
  assign l_ok       = cl_idx < (IDX_W + 2)'(cnt_q);
  assign r_ok       = cr_idx < (IDX_W + 2)'(cnt_q);
  assign push_up    = ent_less(ent_q, h_rdata_a);
  assign do_pop     = (cnt_q != '0) &&
                      (!run_valid_q || (mode_q && (h_rdata_a.key < sat_key(run_rem_q))));
  assign start_stamp = !mode_q || (rt_rd == rem_rd);
  assign push_exit  = (kind_q == KIND_DISPATCH) ? S_START : S_DONE;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_SCHED_MODE) ? {31'd0, mode_q} : 32'd0;

  always_comb begin
    best     = ent_q;
    best_idx = hole_q;
    moved    = 1'b0;
    if (l_ok && ent_less(h_rdata_a, ent_q)) begin
      best     = h_rdata_a;
      best_idx = cl_idx[IDX_W-1:0];
      moved    = 1'b1;
    end
    if (r_ok && ent_less(h_rdata_b, best)) begin
      best     = h_rdata_b;
      best_idx = cr_idx[IDX_W-1:0];
      moved    = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (kind_e'(in_i.kind))
            KIND_ARRIVAL: begin
              if (heap_full) begin
                state_d = S_DONE;
              end else if (cnt_q == '0) begin
                state_d = S_PLACE;
              end else begin
                state_d = S_PUSH;
              end
            end
            KIND_DISPATCH: state_d = S_ROOT;
            default:       state_d = S_DONE;
          endcase
        end
      end
      S_ROOT:  state_d = do_pop ? S_POP : S_DONE;
      S_POP: begin
        if (!moved) begin
          if (!preempt_q) begin
            state_d = S_START;
          end else if (cnt_q == '0) begin
            state_d = S_PLACE;
          end else begin
            state_d = S_PUSH;
          end
        end
      end
      S_PUSH: begin
        if (!push_up) begin
          state_d = push_exit;
        end else if (hole_par == '0) begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: state_d = push_exit;
      S_START: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    mode_d        = mode_q;
    cnt_d         = cnt_q;
    run_valid_d   = run_valid_q;
    run_task_d    = run_task_q;
    run_rem_d     = run_rem_q;
    run_start_d   = run_start_q;
    preempt_d     = preempt_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    kind_d        = kind_q;
    now_d         = now_q;
    fin_d         = fin_q;
    ovf_d         = ovf_q;
    hole_d        = hole_q;
    ent_d         = ent_q;
    t_d           = t_q;
    o_run_valid_d = o_run_valid_q;
    o_run_id_d    = o_run_id_q;
    o_send_d      = o_send_q;
    o_msg_d       = o_msg_q;
    o_start_d     = o_start_q;
    o_fin_d       = o_fin_q;
    o_fin_time_d  = o_fin_time_q;
    o_ovf_d       = o_ovf_q;
    h_we          = 1'b0;
    h_waddr       = hole_q;
    h_wdata       = ent_q;
    h_raddr_a     = '0;
    h_raddr_b     = '0;
    rt_we         = 1'b0;
    rt_waddr      = acc_id;
    rt_wdata      = in_i.run_time;
    rem_we        = 1'b0;
    rem_waddr     = acc_id;
    rem_wdata     = in_i.run_time;
    st_we         = 1'b0;
    st_waddr      = t_q;
    st_wdata      = now_q;
    tab_re        = 1'b0;
    tab_raddr     = h_rdata_a.tid;

    if (psel && penable && pwrite && (paddr == REG_SCHED_MODE)) begin
      mode_d = pwdata[0];
    end

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          kind_d = kind_e'(in_i.kind);
          now_d  = in_i.now;
          fin_d  = 1'b0;
          ovf_d  = 1'b0;
          case (kind_e'(in_i.kind))
            KIND_ARRIVAL: begin
              if (heap_full) begin
                ovf_d = 1'b1;
              end else begin
                rt_we     = 1'b1;
                rem_we    = 1'b1;
                ent_d.key = sat_key(mode_q ? in_i.run_time : in_i.priority_req);
                ent_d.tid = acc_id;
                hole_d    = cnt_q[IDX_W-1:0];
                cnt_d     = cnt_q + CNT_W'(1);
                h_raddr_a = parent_of(cnt_q[IDX_W-1:0]);
                if (acc_id == run_task_q) begin
                  run_rem_d = in_i.run_time;
                end
              end
            end
            KIND_REPORT: begin
              if (run_valid_q) begin
                rem_we    = 1'b1;
                rem_waddr = run_task_q;
                rem_wdata = in_i.reported_remaining;
                run_rem_d = in_i.reported_remaining;
                if (in_i.reported_remaining == 16'd0) begin
                  run_valid_d = 1'b0;
                  fin_d       = 1'b1;
                end
              end
            end
            KIND_DISPATCH: begin
              h_raddr_a = '0;
              h_raddr_b = cnt_m1[IDX_W-1:0];
            end
            default: begin
            end
          endcase
        end
      end
      S_ROOT: begin
        if (do_pop) begin
          t_d       = h_rdata_a.tid;
          tab_re    = 1'b1;
          cnt_d     = cnt_m1;
          hole_d    = '0;
          ent_d     = h_rdata_b;
          preempt_d = run_valid_q;
          h_raddr_a = IDX_W'(child_l('0));
          h_raddr_b = IDX_W'(child_l('0) + (IDX_W + 2)'(1));
        end
      end
      S_POP: begin
        h_we = 1'b1;
        if (moved) begin
          h_wdata   = best;
          hole_d    = best_idx;
          h_raddr_a = IDX_W'(child_l(best_idx));
          h_raddr_b = IDX_W'(child_l(best_idx) + (IDX_W + 2)'(1));
        end else if (preempt_q) begin
          ent_d.key = sat_key(run_rem_q);
          ent_d.tid = run_task_q;
          hole_d    = cnt_q[IDX_W-1:0];
          cnt_d     = cnt_q + CNT_W'(1);
          h_raddr_a = parent_of(cnt_q[IDX_W-1:0]);
        end
      end
      S_PUSH: begin
        h_we = 1'b1;
        if (push_up) begin
          h_wdata   = h_rdata_a;
          hole_d    = hole_par;
          h_raddr_a = parent_of(hole_par);
        end
      end
      S_PLACE: begin
        h_we = 1'b1;
      end
      S_START: begin
        st_we       = start_stamp;
        run_start_d = start_stamp ? now_q : st_rd;
        run_rem_d   = rem_rd;
        run_task_d  = t_q;
        run_valid_d = 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          o_run_valid_d = run_valid_q;
          o_run_id_d    = run_valid_q ? to_id6(run_task_q) : 6'd0;
          o_msg_d       = (kind_q == KIND_DISPATCH) && run_valid_q;
          o_send_d      = ((kind_q == KIND_DISPATCH) && run_valid_q) ? run_rem_q : 16'd0;
          o_start_d     = run_valid_q ? run_start_q : 16'd0;
          o_fin_d       = fin_q;
          o_fin_time_d  = fin_q ? (now_q + 16'd1) : 16'd0;
          o_ovf_d       = ovf_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= 1'b0;
      cnt_q       <= '0;
      run_valid_q <= 1'b0;
      run_task_q  <= '0;
      preempt_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      cnt_q       <= cnt_d;
      run_valid_q <= run_valid_d;
      run_task_q  <= run_task_d;
      preempt_q   <= preempt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_rem_q     <= run_rem_d;
    run_start_q   <= run_start_d;
    kind_q        <= kind_d;
    now_q         <= now_d;
    fin_q         <= fin_d;
    ovf_q         <= ovf_d;
    hole_q        <= hole_d;
    ent_q         <= ent_d;
    t_q           <= t_d;
    o_run_valid_q <= o_run_valid_d;
    o_run_id_q    <= o_run_id_d;
    o_send_q      <= o_send_d;
    o_msg_q       <= o_msg_d;
    o_start_q     <= o_start_d;
    o_fin_q       <= o_fin_d;
    o_fin_time_q  <= o_fin_time_d;
    o_ovf_q       <= o_ovf_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.run_valid      = o_run_valid_q;
  assign out_o.run_id         = o_run_id_q;
  assign out_o.send_remaining = o_send_q;
  assign out_o.msg_valid      = o_msg_q;
  assign out_o.start_time     = o_start_q;
  assign out_o.finished       = o_fin_q;
  assign out_o.finish_time    = o_fin_time_q;
  assign out_o.overflow       = o_ovf_q;

endmodule

// File: hdl/hss_ram.sv
// ---------------------------------------------------------------------------
// Scheduler RAM
// Single write port, single registered read port, write-first on collision.
// ---------------------------------------------------------------------------
module hss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_o <= wdata_i;
      end else begin
        rdata_o <= mem[raddr_i];
      end
    end
  end

endmodule

// File: hdl/hss_checker.sv
// ---------------------------------------------------------------------------
// Scheduler port checker
// Watches the status channel of the scheduler and checks its consistency.
// ---------------------------------------------------------------------------
`include "hpf_srtn_process_scheduler_defines.svh"

module hss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        run_valid_i,
  input logic [5:0]  run_id_i,
  input logic [15:0] send_remaining_i,
  input logic        msg_valid_i,
  input logic [15:0] start_time_i,
  input logic        finished_i,
  input logic [15:0] finish_time_i
);

  `HSS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(run_id_i) && $stable(send_remaining_i) && $stable(finish_time_i))
  `HSS_ASSERT_IMPLY(a_fin_idle, out_valid_i && finished_i, !run_valid_i && !msg_valid_i)
  `HSS_ASSERT_IMPLY(a_msg_run, out_valid_i && msg_valid_i, run_valid_i)
  `HSS_ASSERT_IMPLY(a_idle_zero, out_valid_i && !run_valid_i, (run_id_i == 6'd0) && (start_time_i == 16'd0) && (send_remaining_i == 16'd0))
  `HSS_ASSERT_IMPLY(a_fin_time, out_valid_i && !finished_i, finish_time_i == 16'd0)

endmodule

bind hpf_srtn_process_scheduler hss_checker u_hss_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .run_valid_i      (out_o.run_valid),
  .run_id_i         (out_o.run_id),
  .send_remaining_i (out_o.send_remaining),
  .msg_valid_i      (out_o.msg_valid),
  .start_time_i     (out_o.start_time),
  .finished_i       (out_o.finished),
  .finish_time_i    (out_o.finish_time)
);

// File: verif/hpf_srtn_process_scheduler_test.sv
// ---------------------------------------------------------------------------
// HPF / SRTN process scheduler testbench
// Drives arrival, report, dispatch and no-op words through the input channel,
// predicts every status word with a software copy of the ready heap and task
// table, and checks each status word field by field in both scheduling modes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpf_srtn_process_scheduler_test;
  import hss_pkg::*;

  localparam int         HEAP_DEPTH     = 64;

  typedef struct {
    kind_e       kind;
    logic [5:0]  id;
    logic [15:0] prio;
    logic [15:0] rt;
    logic [15:0] rep;
    logic [15:0] now;
  } event_t;

  typedef struct {
    logic        run_valid;
    logic [5:0]  run_id;
    logic [15:0] send_remaining;
    logic        msg_valid;
    logic [15:0] start_time;
    logic        finished;
    logic [15:0] finish_time;
    logic        overflow;
  } status_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hss_in_if  ev_if ();
  hss_out_if st_if ();

  hpf_srtn_process_scheduler i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (ev_if),
    .out_o   (st_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  event_t  pending_events[$];
  status_t expected_status[$];
  int      error_count;
  int      send_idle_pct;
  int      recv_stall_pct;
  int      hold_cycles;
  bit      word_taken;
  logic [15:0] tick;

  // Scheduler shadow state.
  logic [15:0] q_key [HEAP_DEPTH];
  logic [5:0]  q_tid [HEAP_DEPTH];
  int          q_count;
  bit          cpu_busy;
  logic [5:0]  cpu_task;
  logic [15:0] tab_run [64];
  logic [15:0] tab_rem [64];
  logic [15:0] tab_start [64];
  bit          srtn_mode;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic bit slot_less(int a, int b);
    if (q_key[a] != q_key[b]) return q_key[a] < q_key[b];
    return q_tid[a] < q_tid[b];
  endfunction

  function automatic void slot_swap(int a, int b);
    logic [15:0] k;
    logic [5:0]  t;
    k = q_key[a];
    t = q_tid[a];
    q_key[a] = q_key[b];
    q_tid[a] = q_tid[b];
    q_key[b] = k;
    q_tid[b] = t;
  endfunction

  function automatic void queue_insert(logic [15:0] key, logic [5:0] tid);
    int i;
    int p;
    i = q_count;
    q_key[i] = key;
    q_tid[i] = tid;
    q_count++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!slot_less(i, p)) break;
      slot_swap(i, p);
      i = p;
    end
  endfunction

  function automatic void queue_remove_min();
    int i;
    int l;
    int m;
    i = 0;
    q_count--;
    q_key[0] = q_key[q_count];
    q_tid[0] = q_tid[q_count];
    forever begin
      l = 2 * i + 1;
      m = i;
      if (l < q_count && slot_less(l, m)) m = l;
      if (l + 1 < q_count && slot_less(l + 1, m)) m = l + 1;
      if (m == i) break;
      slot_swap(i, m);
      i = m;
    end
  endfunction

  function automatic void run_task(logic [5:0] t, logic [15:0] now);
    if (!srtn_mode || tab_run[t] == tab_rem[t]) tab_start[t] = now;
    cpu_task = t;
    cpu_busy = 1'b1;
  endfunction

  function automatic status_t schedule_event(event_t ev);
    status_t    s;
    logic [5:0] t;
    logic [5:0] old;
    s = '{default: '0};
    case (ev.kind)
      KIND_ARRIVAL: begin
        if (q_count >= HEAP_DEPTH) begin
          s.overflow = 1'b1;
        end else begin
          tab_run[ev.id] = ev.rt;
          tab_rem[ev.id] = ev.rt;
          queue_insert(srtn_mode ? ev.rt : ev.prio, ev.id);
        end
      end
      KIND_REPORT: begin
        if (cpu_busy) begin
          tab_rem[cpu_task] = ev.rep;
          if (ev.rep == 16'd0) begin
            cpu_busy = 1'b0;
            s.finished = 1'b1;
            s.finish_time = ev.now + 16'd1;
          end
        end
      end
      KIND_DISPATCH: begin
        if (!cpu_busy) begin
          if (q_count > 0) begin
            t = q_tid[0];
            queue_remove_min();
            run_task(t, ev.now);
          end
        end else if (srtn_mode && q_count > 0 && q_key[0] < tab_rem[cpu_task]) begin
          t = q_tid[0];
          old = cpu_task;
          queue_remove_min();
          queue_insert(tab_rem[old], old);
          run_task(t, ev.now);
        end
        if (cpu_busy) begin
          s.msg_valid = 1'b1;
          s.send_remaining = tab_rem[cpu_task];
        end
      end
      default: ;
    endcase
    s.run_valid = cpu_busy;
    s.run_id = cpu_busy ? cpu_task : 6'd0;
    s.start_time = cpu_busy ? tab_start[cpu_task] : 16'd0;
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t: status word mismatch on %s: got %0h, expected %0h", $time, what, got,
             want);
    error_count++;
  endtask

  // Input driver.
  always @(negedge clk_i) begin
    if (!ev_if.valid || word_taken) begin
      if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        ev_if.kind = pending_events[0].kind;
        ev_if.proc_id = pending_events[0].id;
        ev_if.priority_req = pending_events[0].prio;
        ev_if.run_time = pending_events[0].rt;
        ev_if.reported_remaining = pending_events[0].rep;
        ev_if.now = pending_events[0].now;
        void'(pending_events.pop_front());
        ev_if.valid = 1'b1;
      end else begin
        ev_if.valid = 1'b0;
      end
    end
  end

  // Output back-pressure, including the long hold-off.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      st_if.ready = 1'b0;
    end else begin
      st_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Prediction on accept and checking of status words.
  always @(posedge clk_i) begin
    event_t  ev;
    status_t want;
    word_taken = 1'b0;
    if (rst_ni && ev_if.valid && ev_if.ready) begin
      ev.kind = kind_e'(ev_if.kind);
      ev.id = ev_if.proc_id;
      ev.prio = ev_if.priority_req;
      ev.rt = ev_if.run_time;
      ev.rep = ev_if.reported_remaining;
      ev.now = ev_if.now;
      expected_status.push_back(schedule_event(ev));
      word_taken = 1'b1;
    end
    if (rst_ni && st_if.valid && st_if.ready) begin
      if (expected_status.size() == 0) begin
        report_mismatch("unexpected status word", 16'd1, 16'd0);
      end else begin
        want = expected_status.pop_front();
        if (st_if.run_valid !== want.run_valid)
          report_mismatch("run_valid", 16'(st_if.run_valid), 16'(want.run_valid));
        if (st_if.run_id !== want.run_id)
          report_mismatch("run_id", 16'(st_if.run_id), 16'(want.run_id));
        if (st_if.send_remaining !== want.send_remaining)
          report_mismatch("send_remaining", st_if.send_remaining, want.send_remaining);
        if (st_if.msg_valid !== want.msg_valid)
          report_mismatch("msg_valid", 16'(st_if.msg_valid), 16'(want.msg_valid));
        if (st_if.start_time !== want.start_time)
          report_mismatch("start_time", st_if.start_time, want.start_time);
        if (st_if.finished !== want.finished)
          report_mismatch("finished", 16'(st_if.finished), 16'(want.finished));
        if (st_if.finish_time !== want.finish_time)
          report_mismatch("finish_time", st_if.finish_time, want.finish_time);
        if (st_if.overflow !== want.overflow)
          report_mismatch("overflow", 16'(st_if.overflow), 16'(want.overflow));
      end
    end
  end

  function automatic void add_event(kind_e kind, logic [5:0] id, logic [15:0] prio,
                                    logic [15:0] rt, logic [15:0] rep, logic [15:0] now);
    event_t ev;
    ev.kind = kind;
    ev.id = id;
    ev.prio = prio;
    ev.rt = rt;
    ev.rep = rep;
    ev.now = now;
    pending_events.push_back(ev);
  endfunction

  function automatic logic [15:0] rand_span();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(15));
      1:       return 16'($urandom_range(300));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void add_random_events(int count, int arrival_pct);
    int     r;
    kind_e  k;
    logic [15:0] rep;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < arrival_pct) k = KIND_ARRIVAL;
      else if (r < arrival_pct + (100 - arrival_pct) * 2 / 5) k = KIND_REPORT;
      else if (r < 96) k = KIND_DISPATCH;
      else k = KIND_NOP;
      rep = ($urandom_range(99) < 40) ? 16'd0 : rand_span();
      tick = tick + 16'($urandom_range(40));
      add_event(k, 6'($urandom), rand_span(), rand_span(), rep,
                ($urandom_range(19) == 0) ? 16'($urandom) : tick);
    end
  endfunction

  task automatic wait_drained();
    wait (pending_events.size() == 0 && !ev_if.valid && expected_status.size() == 0);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_mode(bit mode);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = REG_SCHED_MODE;
    pwdata = {31'd0, mode};
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    srtn_mode = mode;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic run_phase(bit mode, int idle, int stall, int count, int arrival_pct);
    wait_drained();
    write_mode(mode);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    add_random_events(count, arrival_pct);
  endtask

  initial begin
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    word_taken = 1'b0;
    tick = 16'd0;
    q_count = 0;
    cpu_busy = 1'b0;
    cpu_task = 6'd0;
    srtn_mode = 1'b0;
    for (int i = 0; i < 64; i++) begin
      q_key[i] = '0;
      q_tid[i] = '0;
      tab_run[i] = '0;
      tab_rem[i] = '0;
      tab_start[i] = '0;
    end
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    ev_if.valid = 1'b0;
    ev_if.kind = KIND_NOP;
    ev_if.proc_id = '0;
    ev_if.priority_req = '0;
    ev_if.run_time = '0;
    ev_if.reported_remaining = '0;
    ev_if.now = '0;
    st_if.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_mode(1'b0);
    add_event(KIND_DISPATCH, 6'd0, 16'd0, 16'd0, 16'd0, 16'd5);
    add_event(KIND_REPORT, 6'd0, 16'd0, 16'd0, 16'd0, 16'd6);
    add_event(KIND_NOP, 6'h3f, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    add_event(KIND_ARRIVAL, 6'd63, 16'hffff, 16'hffff, 16'd0, 16'd7);
    add_event(KIND_ARRIVAL, 6'd9, 16'd4, 16'd0, 16'd0, 16'd7);
    add_event(KIND_ARRIVAL, 6'd3, 16'd4, 16'd20, 16'd0, 16'd8);
    add_event(KIND_ARRIVAL, 6'd0, 16'd0, 16'd30, 16'd0, 16'd8);
    add_event(KIND_DISPATCH, 6'd0, 16'd0, 16'd0, 16'd0, 16'd10);
    add_event(KIND_DISPATCH, 6'd0, 16'd0, 16'd0, 16'd0, 16'd11);
    add_event(KIND_REPORT, 6'd0, 16'd0, 16'd0, 16'd12, 16'd12);
    add_event(KIND_REPORT, 6'd0, 16'd0, 16'd0, 16'd0, 16'hffff);
    add_event(KIND_DISPATCH, 6'd0, 16'd0, 16'd0, 16'd0, 16'd20);
    add_event(KIND_ARRIVAL, 6'd3, 16'd1, 16'd25, 16'd0, 16'd21);
    add_event(KIND_DISPATCH, 6'd0, 16'd0, 16'd0, 16'd0, 16'd22);
    wait_drained();
    write_mode(1'b1);
    add_event(KIND_REPORT, 6'd0, 16'd0, 16'd0, 16'd0, 16'd30);
    add_event(KIND_DISPATCH, 6'd0, 16'd0, 16'd0, 16'd0, 16'd31);
    add_event(KIND_ARRIVAL, 6'd5, 16'd0, 16'd2, 16'd0, 16'd32);
    add_event(KIND_ARRIVAL, 6'd4, 16'd0, 16'd2, 16'd0, 16'd32);
    add_event(KIND_DISPATCH, 6'd0, 16'd0, 16'd0, 16'd0, 16'd33);
    add_event(KIND_REPORT, 6'd0, 16'd0, 16'd0, 16'd1, 16'd34);
    add_event(KIND_DISPATCH, 6'd0, 16'd0, 16'd0, 16'd0, 16'd35);
    add_event(KIND_ARRIVAL, 6'd4, 16'd0, 16'hffff, 16'd0, 16'd36);

    run_phase(1'b0, 0, 0, 60, 35);
    run_phase(1'b1, 72, 0, 60, 35);
    run_phase(1'b1, 0, 72, 60, 35);
    // Fill the heap past its depth so that arrivals are dropped.
    run_phase(1'b1, 26, 26, 80, 95);
    add_random_events(30, 10);
    run_phase(1'b0, 0, 0, 30, 30);
    hold_cycles = 300;
    add_random_events(30, 30);
    run_phase(1'b0, 26, 26, 50, 35);
    run_phase(1'b1, 0, 0, 40, 40);
    wait_drained();
    write_mode(1'b0);
    wait_drained();

    if (expected_status.size() != 0) begin
      report_mismatch("missing status words", 16'(expected_status.size()), 16'd0);
    end
    if (error_count == 0) begin
      $display("hpf_srtn_process_scheduler_test: done, clean");
    end else begin
      $display("hpf_srtn_process_scheduler_test: done, errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("hpf_srtn_process_scheduler_test: done, errors");
    $finish;
  end

endmodule
